[sv/bhcs_pkg.sv]
package bhcs_pkg;

  // Build-time figures of the drive and the speed measurement.
  localparam int unsigned PWM_FREQ_HZ = 16000;
  localparam int unsigned POLE_PAIRS  = 2;

  localparam int unsigned HALL_W   = 3;
  localparam int unsigned DUTY_W   = 12;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned STALL_W  = 16;
  localparam int unsigned COEFF_W  = 10;
  localparam int unsigned RPM_W    = 18;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned SPEED_W  = RPM_W + FRAC_W;
  localparam int unsigned FAULT_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [RPM_W-1:0]   RPM_MAX   = {RPM_W{1'b1}};

  // raw = floor(60 * f_pwm / (count * 2 * pole_pairs)); the nested truncating
  // divisions of the speed formula collapse into this single one.
  localparam int unsigned RAW_NUM   = 60 * PWM_FREQ_HZ;
  localparam int unsigned RAW_K     = 2 * POLE_PAIRS;
  localparam int unsigned NUM_W     = $clog2(RAW_NUM + 1);
  localparam int unsigned RAW_K_W   = $clog2(RAW_K + 1);
  localparam int unsigned DEN_W     = COUNT_W + RAW_K_W;

  // Filter arithmetic: weight in Q0.10, speed in Q18.8.
  localparam int unsigned COEFF_ONE  = 1 << COEFF_W;
  localparam int unsigned WGT_W      = COEFF_W + 1;
  localparam int unsigned MUL_P_W    = WGT_W + SPEED_W;
  localparam int unsigned ACC_W      = MUL_P_W + 1;
  localparam int unsigned ROUND_HALF = 1 << (COEFF_W - 1);

  localparam logic                 DIRECTION_RST    = 1'b0;
  localparam logic [STALL_W-1:0]   STALL_LIMIT_RST  = STALL_W'(15000);
  localparam logic [COEFF_W-1:0]   FILTER_COEFF_RST = COEFF_W'(244);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION    = 2'd0,
    CFG_STALL_LIMIT  = 2'd1,
    CFG_FILTER_COEFF = 2'd2
  } cfg_idx_e;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_HALL  = 2'd1,
    FAULT_STALL = 2'd2
  } fault_e;

  // High-side phase driven for steps 1 to 6 (0 U, 1 V, 2 W).
  function automatic logic [1:0] hi_phase(input logic [HALL_W-1:0] step);
    logic [1:0] ph;
    case (step)
      3'd1:    ph = 2'd0;
      3'd2:    ph = 2'd1;
      3'd3:    ph = 2'd1;
      3'd4:    ph = 2'd2;
      3'd5:    ph = 2'd0;
      3'd6:    ph = 2'd2;
      default: ph = 2'd0;
    endcase
    return ph;
  endfunction

  // Low-side switches for steps 1 to 6, bit 0 U, bit 1 V, bit 2 W.
  function automatic logic [2:0] lo_bits(input logic [HALL_W-1:0] step);
    logic [2:0] lb;
    case (step)
      3'd1:    lb = 3'b100;
      3'd2:    lb = 3'b001;
      3'd3:    lb = 3'b100;
      3'd4:    lb = 3'b010;
      3'd5:    lb = 3'b010;
      3'd6:    lb = 3'b001;
      default: lb = 3'b000;
    endcase
    return lb;
  endfunction

endpackage

[sv/bhcs_if.sv]
interface bhcs_in_if;
  import bhcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [HALL_W-1:0] hall;
  logic [DUTY_W-1:0] duty;
  logic              start_req;

  modport source (output valid, hall, duty, start_req, input ready);
  modport sink   (input valid, hall, duty, start_req, output ready);
endinterface

interface bhcs_out_if;
  import bhcs_pkg::*;

  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  duty_u;
  logic [DUTY_W-1:0]  duty_v;
  logic [DUTY_W-1:0]  duty_w;
  logic               low_u;
  logic               low_v;
  logic               low_w;
  logic               pwm_enabled;
  logic               is_running;
  logic [HALL_W-1:0]  step_value;
  logic [RPM_W-1:0]   speed_rpm;
  logic [FAULT_W-1:0] fault;

  modport source (
    output valid, duty_u, duty_v, duty_w, low_u, low_v, low_w, pwm_enabled,
           is_running, step_value, speed_rpm, fault,
    input  ready
  );
  modport sink (
    input  valid, duty_u, duty_v, duty_w, low_u, low_v, low_w, pwm_enabled,
           is_running, step_value, speed_rpm, fault,
    output ready
  );
endinterface

[sv/bhcs_div.sv]
module bhcs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bhcs_pkg::DEN_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [bhcs_pkg::NUM_W-1:0] quot_o
);
  import bhcs_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Restoring division of the fixed numerator, one quotient bit a cycle.
  // The numerator register fills with quotient bits from the bottom.
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    num_d  = num_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      rem_d  = '0;
      den_d  = divisor_i;
      num_d  = NUM_W'(RAW_NUM);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      num_d = {num_q[NUM_W-2:0], fits};
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    num_q <= num_d;
  end

  assign done_o = busy_q && (cnt_q == CNT_W'(1));
  assign quot_o = num_q;

endmodule

[sv/bldc_hall_commutator_speed_unit.sv]
// One transfer in per PWM tick, one result out per tick.
// A tick without a falling edge of step bit 0 passes through S_DONE into the output register.
// A falling edge adds a serial divide, then S_MUL_A and S_MUL_B on one shared multiplier and
// S_SUM for the filter; no new tick is taken until its result is in the output register.
// A new tick is taken while an earlier result still waits in the output register.
// Reset (asynchronous, active low) stops the motor, clears all counters and the speed.
module bldc_hall_commutator_speed_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bhcs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bhcs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bhcs_in_if.sink                        in_if,
  bhcs_out_if.source                     out_if
);
  import bhcs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_MUL_A = 6'b000100,
    S_MUL_B = 6'b001000,
    S_SUM   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration.
  logic               direction_q;
  logic [STALL_W-1:0] stall_limit_q;
  logic [COEFF_W-1:0] coeff_q;

  // Drive and measurement state.
  logic               running_q, running_d;
  logic               outputs_on_q, outputs_on_d;
  logic [2:0]         low_q, low_d;
  logic [DUTY_W-1:0]  pduty_q [3];
  logic [DUTY_W-1:0]  pduty_d [3];
  logic               last_bit_q, last_bit_d;
  logic [COUNT_W-1:0] high_cnt_q, high_cnt_d;
  logic [COUNT_W-1:0] unch_cnt_q, unch_cnt_d;
  logic [SPEED_W-1:0] speed_q, speed_d;
  logic [HALL_W-1:0]  step_q, step_d;
  logic [FAULT_W-1:0] fault_q, fault_d;
  logic [ACC_W-1:0]   acc_q, acc_d;

  // Output register.
  logic               ovalid_q, ovalid_d;
  logic [DUTY_W-1:0]  o_duty_q [3];
  logic [2:0]         o_low_q;
  logic               o_pwm_q, o_run_q;
  logic [HALL_W-1:0]  o_step_q;
  logic [RPM_W-1:0]   o_rpm_q;
  logic [FAULT_W-1:0] o_fault_q;
  logic               o_load;

  logic               accept;
  logic [HALL_W-1:0]  step;
  logic               run;
  logic               bit0;
  logic [COUNT_W-1:0] high_inc, unch_inc;
  logic               div_start, div_done;
  logic [DEN_W-1:0]   divisor;
  logic [NUM_W-1:0]   quot;
  logic [RPM_W-1:0]   raw;
  logic [WGT_W-1:0]   mul_a;
  logic [SPEED_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == S_IDLE);

  assign step     = direction_q ? HALL_W'(3'd7 - in_if.hall) : in_if.hall;
  assign run      = running_q || in_if.start_req;
  assign bit0     = step[0];
  assign high_inc = (high_cnt_q == COUNT_MAX) ? high_cnt_q : high_cnt_q + 1'b1;
  assign unch_inc = (unch_cnt_q == COUNT_MAX) ? unch_cnt_q : unch_cnt_q + 1'b1;
  assign divisor  = DEN_W'(high_inc * RAW_K);

  assign raw = (quot > NUM_W'(RPM_MAX)) ? RPM_MAX : quot[RPM_W-1:0];

  bhcs_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // The one multiplier serves both filter terms on successive cycles.
  always_comb begin
    if (state_q == S_MUL_A) begin
      mul_a = WGT_W'(COEFF_ONE) - WGT_W'(coeff_q);
      mul_b = speed_q;
    end else begin
      mul_a = WGT_W'(coeff_q);
      mul_b = SPEED_W'(raw);
    end
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_d      = state_q;
    running_d    = running_q;
    outputs_on_d = outputs_on_q;
    low_d        = low_q;
    pduty_d      = pduty_q;
    last_bit_d   = last_bit_q;
    high_cnt_d   = high_cnt_q;
    unch_cnt_d   = unch_cnt_q;
    speed_d      = speed_q;
    step_d       = step_q;
    fault_d      = fault_q;
    acc_d        = acc_q;
    div_start    = 1'b0;
    o_load       = 1'b0;
    ovalid_d     = ovalid_q;

    if (ovalid_q && out_if.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          step_d  = step;
          fault_d = FAULT_NONE;
          state_d = S_DONE;
          if (run) begin
            running_d    = 1'b1;
            outputs_on_d = 1'b1;
            if (step != 3'd0 && step != 3'd7) begin
              pduty_d[0] = '0;
              pduty_d[1] = '0;
              pduty_d[2] = '0;
              pduty_d[hi_phase(step)] = in_if.duty;
              low_d = lo_bits(step);
            end else begin
              running_d    = 1'b0;
              outputs_on_d = 1'b0;
              low_d        = '0;
              pduty_d[0]   = '0;
              pduty_d[1]   = '0;
              pduty_d[2]   = '0;
              fault_d      = FAULT_HALL;
            end
            if (bit0 != last_bit_q) begin
              last_bit_d = bit0;
              high_cnt_d = '0;
              unch_cnt_d = '0;
              if (!bit0) begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end else begin
              high_cnt_d = high_inc;
              unch_cnt_d = unch_inc;
              if (unch_inc > stall_limit_q) begin
                running_d    = 1'b0;
                outputs_on_d = 1'b0;
                low_d        = '0;
                pduty_d[0]   = '0;
                pduty_d[1]   = '0;
                pduty_d[2]   = '0;
                unch_cnt_d   = '0;
                speed_d      = '0;
                fault_d      = FAULT_STALL;
              end
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_MUL_A;
        end
      end
      S_MUL_A: begin
        acc_d   = ACC_W'(mul_p) + ACC_W'(ROUND_HALF);
        state_d = S_MUL_B;
      end
      S_MUL_B: begin
        acc_d   = acc_q + {mul_p[ACC_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
        state_d = S_SUM;
      end
      S_SUM: begin
        speed_d = acc_q[COEFF_W +: SPEED_W];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_q || out_if.ready) begin
          o_load   = 1'b1;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      direction_q   <= DIRECTION_RST;
      stall_limit_q <= STALL_LIMIT_RST;
      coeff_q       <= FILTER_COEFF_RST;
      running_q     <= 1'b0;
      outputs_on_q  <= 1'b0;
      low_q         <= '0;
      pduty_q[0]    <= '0;
      pduty_q[1]    <= '0;
      pduty_q[2]    <= '0;
      last_bit_q    <= 1'b0;
      high_cnt_q    <= '0;
      unch_cnt_q    <= '0;
      speed_q       <= '0;
      ovalid_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      running_q    <= running_d;
      outputs_on_q <= outputs_on_d;
      low_q        <= low_d;
      pduty_q      <= pduty_d;
      last_bit_q   <= last_bit_d;
      high_cnt_q   <= high_cnt_d;
      unch_cnt_q   <= unch_cnt_d;
      speed_q      <= speed_d;
      ovalid_q     <= ovalid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DIRECTION:    direction_q   <= cfg_data_i[0];
          CFG_STALL_LIMIT:  stall_limit_q <= cfg_data_i[STALL_W-1:0];
          CFG_FILTER_COEFF: coeff_q       <= cfg_data_i[COEFF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    fault_q <= fault_d;
    acc_q   <= acc_d;
    if (o_load) begin
      o_duty_q  <= pduty_q;
      o_low_q   <= low_q;
      o_pwm_q   <= outputs_on_q;
      o_run_q   <= running_q;
      o_step_q  <= step_q;
      o_rpm_q   <= speed_q[FRAC_W +: RPM_W];
      o_fault_q <= fault_q;
    end
  end

  assign out_if.valid       = ovalid_q;
  assign out_if.duty_u      = o_duty_q[0];
  assign out_if.duty_v      = o_duty_q[1];
  assign out_if.duty_w      = o_duty_q[2];
  assign out_if.low_u       = o_low_q[0];
  assign out_if.low_v       = o_low_q[1];
  assign out_if.low_w       = o_low_q[2];
  assign out_if.pwm_enabled = o_pwm_q;
  assign out_if.is_running  = o_run_q;
  assign out_if.step_value  = o_step_q;
  assign out_if.speed_rpm   = o_rpm_q;
  assign out_if.fault       = o_fault_q;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import bhcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned HOLDOFF_AT = 250;

  typedef struct packed {
    logic [HALL_W-1:0] hall;
    logic [DUTY_W-1:0] duty;
    logic              start_req;
  } pwm_tick_t;

  typedef struct {
    logic [DUTY_W-1:0] duty_u;
    logic [DUTY_W-1:0] duty_v;
    logic [DUTY_W-1:0] duty_w;
    logic              low_u;
    logic              low_v;
    logic              low_w;
    logic              pwm_enabled;
    logic              is_running;
    logic [HALL_W-1:0] step_value;
    logic [RPM_W-1:0]  speed_rpm;
    fault_e            fault;
  } bridge_state_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bhcs_in_if  in_if ();
  bhcs_out_if out_if ();

  bldc_hall_commutator_speed_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  // Register copies held by the commutation predictor.
  logic               reverse_dir;
  logic [STALL_W-1:0] stall_ticks_max;
  logic [COEFF_W-1:0] speed_weight;

  // Commutator state as the predictor sees it.
  logic               motor_running;
  logic               bridge_on;
  logic [2:0]         low_side;
  logic [DUTY_W-1:0]  high_duty [3];
  logic               prev_step_bit;
  logic [COUNT_W-1:0] high_ticks;
  logic [COUNT_W-1:0] quiet_ticks;
  logic [SPEED_W-1:0] speed_q8;

  pwm_tick_t     tick_q [$];
  bridge_state_t bridge_q [$];
  pwm_tick_t     offered_tick;

  int unsigned err_cnt;
  int unsigned results_seen;
  int unsigned cycle_cnt;
  int          burst_left;
  int          gap_left;
  int          holdoff_left;
  logic        holdoff_done;
  logic [7:0]  ready_pattern;
  int          pattern_age;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic void halt_motor();
    bridge_on = 1'b0;
    motor_running = 1'b0;
    low_side = 3'b000;
    high_duty[0] = '0;
    high_duty[1] = '0;
    high_duty[2] = '0;
  endfunction

  function automatic logic [HALL_W-1:0] hall_at(input int pos);
    logic [HALL_W-1:0] h;
    // Gray-coded hall order of one electrical revolution.
    case (pos)
      0:       h = 3'd1;
      1:       h = 3'd3;
      2:       h = 3'd2;
      3:       h = 3'd6;
      4:       h = 3'd4;
      default: h = 3'd5;
    endcase
    return h;
  endfunction

  function automatic bridge_state_t commutate_tick(input pwm_tick_t t);
    bridge_state_t     r;
    logic [HALL_W-1:0] step;
    logic              step_bit;
    logic [63:0]       raw_rpm;
    logic [63:0]       acc;
    fault_e            flt;
    step = reverse_dir ? 3'd7 - t.hall : t.hall;
    flt = FAULT_NONE;
    if (t.start_req) begin
      bridge_on = 1'b1;
      motor_running = 1'b1;
    end
    if (motor_running) begin
      if (step != 3'd0 && step != 3'd7) begin
        high_duty[0] = '0;
        high_duty[1] = '0;
        high_duty[2] = '0;
        case (step)
          3'd1: begin
            high_duty[0] = t.duty;
            low_side = 3'b100;
          end
          3'd2: begin
            high_duty[1] = t.duty;
            low_side = 3'b001;
          end
          3'd3: begin
            high_duty[1] = t.duty;
            low_side = 3'b100;
          end
          3'd4: begin
            high_duty[2] = t.duty;
            low_side = 3'b010;
          end
          3'd5: begin
            high_duty[0] = t.duty;
            low_side = 3'b010;
          end
          default: begin
            high_duty[2] = t.duty;
            low_side = 3'b001;
          end
        endcase
      end else begin
        halt_motor();
        flt = FAULT_HALL;
      end
      if (high_ticks != '1) high_ticks = high_ticks + 1'b1;
      step_bit = step[0];
      if (step_bit != prev_step_bit) begin
        prev_step_bit = step_bit;
        if (!step_bit) begin
          raw_rpm = 64'(60 * PWM_FREQ_HZ) / 64'(high_ticks);
          raw_rpm = raw_rpm / 64'd2;
          raw_rpm = raw_rpm / 64'(POLE_PAIRS);
          if (raw_rpm > 64'(RPM_MAX)) raw_rpm = 64'(RPM_MAX);
          acc = (64'd1024 - 64'(speed_weight)) * 64'(speed_q8)
              + 64'(speed_weight) * (raw_rpm << 8) + 64'd512;
          speed_q8 = SPEED_W'(acc >> 10);
        end
        quiet_ticks = '0;
        high_ticks = '0;
      end else begin
        if (quiet_ticks != '1) quiet_ticks = quiet_ticks + 1'b1;
        if (quiet_ticks > stall_ticks_max) begin
          halt_motor();
          quiet_ticks = '0;
          speed_q8 = '0;
          flt = FAULT_STALL;
        end
      end
    end
    r.duty_u = high_duty[0];
    r.duty_v = high_duty[1];
    r.duty_w = high_duty[2];
    r.low_u = low_side[0];
    r.low_v = low_side[1];
    r.low_w = low_side[2];
    r.pwm_enabled = bridge_on;
    r.is_running = motor_running;
    r.step_value = step;
    r.speed_rpm = speed_q8[SPEED_W-1:FRAC_W];
    r.fault = flt;
    return r;
  endfunction

  // Sender: bursts of transfers separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) bridge_q.push_back(commutate_tick(offered_tick));
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          offered_tick = tick_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.hall <= offered_tick.hall;
          in_if.duty <= offered_tick.duty;
          in_if.start_req <= offered_tick.start_req;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Receiver: checks each result and stalls on a rotating pattern.
  always @(posedge clk_i) begin
    bridge_state_t e;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (bridge_q.size() == 0) begin
          $error("result transfer with no expectation pending");
          err_cnt++;
        end else begin
          e = bridge_q.pop_front();
          check_field("duty_u", e.duty_u, out_if.duty_u);
          check_field("duty_v", e.duty_v, out_if.duty_v);
          check_field("duty_w", e.duty_w, out_if.duty_w);
          check_field("low_u", e.low_u, out_if.low_u);
          check_field("low_v", e.low_v, out_if.low_v);
          check_field("low_w", e.low_w, out_if.low_w);
          check_field("pwm_enabled", e.pwm_enabled, out_if.pwm_enabled);
          check_field("is_running", e.is_running, out_if.is_running);
          check_field("step_value", e.step_value, out_if.step_value);
          check_field("speed_rpm", e.speed_rpm, out_if.speed_rpm);
          check_field("fault", e.fault, out_if.fault);
        end
      end
      if (!holdoff_done && results_seen >= HOLDOFF_AT && tick_q.size() >= 4) begin
        // A long hold-off lets the block fill up and push back on its input.
        holdoff_done <= 1'b1;
        holdoff_left <= HOLDOFF_CYCLES;
        out_if.ready <= 1'b0;
      end else if (holdoff_left > 0) begin
        holdoff_left <= holdoff_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ready_pattern[0];
        if (pattern_age >= 50) begin
          pattern_age <= 0;
          ready_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom) | 8'h11;
        end else begin
          pattern_age <= pattern_age + 1;
          ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_tick(input logic [HALL_W-1:0] hall, input logic [DUTY_W-1:0] duty,
                           input logic start_req);
    pwm_tick_t t;
    t.hall = hall;
    t.duty = duty;
    t.start_req = start_req;
    tick_q.push_back(t);
  endtask

  function automatic logic [DUTY_W-1:0] rand_duty();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return DUTY_W'($urandom);
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || in_if.valid || bridge_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DIRECTION:    reverse_dir = val[0];
      CFG_STALL_LIMIT:  stall_ticks_max = val[STALL_W-1:0];
      CFG_FILTER_COEFF: speed_weight = val[COEFF_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Mostly clean rotations with random hold times, some scrambled hall noise.
  task automatic gen_rotation(input int n);
    int   made;
    int   pos;
    int   hold;
    logic backwards;
    logic first;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) < 8) begin
        pos = $urandom_range(0, 5);
        backwards = 1'($urandom_range(0, 1));
        first = 1'b1;
        repeat ($urandom_range(2, 14)) begin
          hold = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 5);
          repeat (hold) begin
            if (made < n) begin
              push_tick(hall_at(pos), rand_duty(),
                        first ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 40) == 0));
              first = 1'b0;
              made++;
            end
          end
          pos = backwards ? (pos + 5) % 6 : (pos + 1) % 6;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if (made < n) begin
            push_tick(HALL_W'($urandom_range(0, 7)), rand_duty(), 1'($urandom_range(0, 1)));
            made++;
          end
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_DIRECTION;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.hall = '0;
    in_if.duty = '0;
    in_if.start_req = 1'b0;
    out_if.ready = 1'b0;
    err_cnt = 0;
    results_seen = 0;
    cycle_cnt = 0;
    burst_left = 1;
    gap_left = 0;
    holdoff_left = 0;
    holdoff_done = 1'b0;
    ready_pattern = 8'hFF;
    pattern_age = 0;
    reverse_dir = DIRECTION_RST;
    stall_ticks_max = STALL_LIMIT_RST;
    speed_weight = FILTER_COEFF_RST;
    halt_motor();
    prev_step_bit = 1'b0;
    high_ticks = '0;
    quiet_ticks = '0;
    speed_q8 = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: idle ticks, invalid halls, a clean turn, then a fault stop.
    push_tick(3'd3, 12'd4095, 1'b0);
    push_tick(3'd0, 12'd100, 1'b1);
    push_tick(3'd7, 12'd200, 1'b1);
    push_tick(3'd1, 12'd4095, 1'b1);
    push_tick(3'd1, 12'd0, 1'b0);
    push_tick(3'd3, 12'd4095, 1'b0);
    push_tick(3'd2, 12'd1234, 1'b0);
    push_tick(3'd6, 12'd2048, 1'b0);
    push_tick(3'd4, 12'd1, 1'b0);
    push_tick(3'd5, 12'd4094, 1'b0);
    push_tick(3'd5, 12'd777, 1'b0);
    push_tick(3'd4, 12'd3000, 1'b0);
    push_tick(3'd0, 12'd55, 1'b0);
    push_tick(3'd6, 12'd4095, 1'b0);
    push_tick(3'd2, 12'd0, 1'b1);
    wait_idle();

    // Reverse with a zero stall limit: stalls, and stall winning over a bad hall.
    write_reg(CFG_DIRECTION, 16'd1);
    write_reg(CFG_STALL_LIMIT, 16'd0);
    write_reg(CFG_FILTER_COEFF, 16'd1023);
    push_tick(3'd6, 12'd10, 1'b1);
    push_tick(3'd6, 12'd20, 1'b0);
    push_tick(3'd6, 12'd30, 1'b1);
    push_tick(3'd1, 12'd40, 1'b1);
    push_tick(3'd7, 12'd50, 1'b1);
    push_tick(3'd5, 12'd60, 1'b1);
    push_tick(3'd2, 12'd4095, 1'b0);
    push_tick(3'd4, 12'd70, 1'b0);
    wait_idle();

    write_reg(CFG_DIRECTION, 16'd0);
    write_reg(CFG_STALL_LIMIT, 16'd65535);
    gen_rotation(120);
    wait_idle();

    write_reg(CFG_DIRECTION, 16'd1);
    write_reg(CFG_STALL_LIMIT, 16'd5);
    write_reg(CFG_FILTER_COEFF, 16'd0);
    gen_rotation(110);
    wait_idle();

    write_reg(CFG_DIRECTION, 16'd0);
    write_reg(CFG_STALL_LIMIT, 16'($urandom_range(2, 40)));
    write_reg(CFG_FILTER_COEFF, 16'd1);
    gen_rotation(110);
    wait_idle();

    write_reg(CFG_STALL_LIMIT, 16'd15000);
    write_reg(CFG_FILTER_COEFF, 16'd244);
    gen_rotation(110);
    wait_idle();

    write_reg(CFG_DIRECTION, 16'($urandom_range(0, 1)));
    write_reg(CFG_STALL_LIMIT, 16'($urandom_range(0, 20)));
    write_reg(CFG_FILTER_COEFF, 16'($urandom_range(0, 1023)));
    gen_rotation(100);
    wait_idle();

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/bhcs_pkg.sv
sv/bhcs_if.sv
sv/bhcs_div.sv
sv/bldc_hall_commutator_speed_unit.sv
bench/testbench.sv
